/* rtl/tkb_pkg.sv */
// ----------------------------------------------------------------------------
// tkb_pkg: shared types and constants of the top-k best keeper
// Transaction structs, request codes, field widths and register defaults.
// ----------------------------------------------------------------------------
package tkb_pkg;

	// Table size is bounded by the rank field and the result burst length
	localparam int TABLE_MAX    = 16;
	localparam int CAPACITY_DEF = 16;

	// Field widths
	localparam int FIT_W  = 32;
	localparam int TAG_W  = 16;
	localparam int RANK_W = 4;
	localparam int CNT_W  = 5;

	// Request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	// Register map: register select is paddr[2]
	localparam logic REG_MAX_ENTRIES = 1'b0;
	localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 5'd16;

	// Input transaction
	typedef struct packed {
		logic                    req_type;
		logic signed [FIT_W-1:0] new_fitness;
		logic [TAG_W-1:0]        new_tag;
	} in_item_t;

	// Result transaction
	typedef struct packed {
		logic                    entry_valid;
		logic [RANK_W-1:0]       entry_rank;
		logic signed [FIT_W-1:0] entry_fitness;
		logic [TAG_W-1:0]        entry_tag;
		logic                    was_kept;
		logic [CNT_W-1:0]        filled_count;
		logic                    run_end;
	} out_item_t;

	// Insert decision handed from the chain to the controller
	typedef struct packed {
		logic             kept;
		logic [CNT_W-1:0] pos;
	} ins_status_t;

endpackage

/* rtl/tkb_cell.sv */
// ----------------------------------------------------------------------------
// tkb_cell: one rank slot of the sorted chain
// Holds one entry, compares it with the candidate, and on an insert keeps
// its entry, takes the candidate, or takes the entry of the better neighbor.
// ----------------------------------------------------------------------------
module tkb_cell (
	input  logic                             clk,
	input  logic                             occ,
	input  logic                             less_prev,
	input  logic signed [tkb_pkg::FIT_W-1:0] prev_fit,
	input  logic [tkb_pkg::TAG_W-1:0]        prev_tag,
	input  logic signed [tkb_pkg::FIT_W-1:0] cand_fit,
	input  logic [tkb_pkg::TAG_W-1:0]        cand_tag,
	input  logic                             load,
	output logic                             less,
	output logic                             eq,
	output logic signed [tkb_pkg::FIT_W-1:0] fit,
	output logic [tkb_pkg::TAG_W-1:0]        tag
);
	import tkb_pkg::*;

	logic signed [FIT_W-1:0] fit_q;
	logic [TAG_W-1:0]        tag_q;

	// Compare the stored entry against the candidate
	assign less = occ && (fit_q < cand_fit);
	assign eq   = occ && (fit_q == cand_fit);
	assign fit  = fit_q;
	assign tag  = tag_q;

	// Keep a better entry, take the candidate at its rank, shift the rest down
	always_ff @(posedge clk) begin
		if (load && !less) begin
			if (less_prev) begin
				fit_q <= cand_fit;
				tag_q <= cand_tag;
			end else begin
				fit_q <= prev_fit;
				tag_q <= prev_tag;
			end
		end
	end

endmodule

/* rtl/tkb_chain.sv */
// ----------------------------------------------------------------------------
// tkb_chain: row of rank cells
// Links the cells best to worst, finds the candidate's rank, flags equal
// fitness, and decides whether the candidate stays under the limit.
// ----------------------------------------------------------------------------
module tkb_chain #(
	parameter int DEPTH = tkb_pkg::TABLE_MAX
) (
	input  logic                             clk,
	input  logic [DEPTH-1:0]                 occ,
	input  logic signed [tkb_pkg::FIT_W-1:0] cand_fit,
	input  logic [tkb_pkg::TAG_W-1:0]        cand_tag,
	input  logic [tkb_pkg::CNT_W-1:0]        lim,
	input  logic                             go,
	output tkb_pkg::ins_status_t             status,
	output logic signed [tkb_pkg::FIT_W-1:0] fit_arr [DEPTH],
	output logic [tkb_pkg::TAG_W-1:0]        tag_arr [DEPTH]
);
	import tkb_pkg::*;

	logic [DEPTH-1:0] less_vec;
	logic [DEPTH-1:0] eq_vec;
	logic [CNT_W-1:0] pos;
	logic             load;

	// Build the chain: cell 0 sees the candidate as its better neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			tkb_cell u_cell (
				.clk      (clk),
				.occ      (occ[i]),
				.less_prev(1'b1),
				.prev_fit (cand_fit),
				.prev_tag (cand_tag),
				.cand_fit (cand_fit),
				.cand_tag (cand_tag),
				.load     (load),
				.less     (less_vec[i]),
				.eq       (eq_vec[i]),
				.fit      (fit_arr[i]),
				.tag      (tag_arr[i])
			);
		end else begin : g_body
			tkb_cell u_cell (
				.clk      (clk),
				.occ      (occ[i]),
				.less_prev(less_vec[i-1]),
				.prev_fit (fit_arr[i-1]),
				.prev_tag (tag_arr[i-1]),
				.cand_fit (cand_fit),
				.cand_tag (cand_tag),
				.load     (load),
				.less     (less_vec[i]),
				.eq       (eq_vec[i]),
				.fit      (fit_arr[i]),
				.tag      (tag_arr[i])
			);
		end
	end

	// Count better entries to get the candidate's rank
	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pos = pos + CNT_W'(less_vec[i]);
		end
	end

	// Keep only a new fitness that ranks inside the limit and equals no stored fitness
	assign status.pos  = pos;
	assign status.kept = !(|eq_vec) && (pos < lim);
	assign load        = go && status.kept;

endmodule

/* rtl/top_k_best_keeper.sv */
// ----------------------------------------------------------------------------
// top_k_best_keeper: sorted table of the best fitness entries
// Inserts candidates at their rank in a chain of cells, trims to the limit
// and reads the table out in rank order.
//
//   channel   dir  handshake                   payload
//   in        in   in_valid / in_ready         tkb_pkg::in_item_t
//   out       out  out_valid / out_ready       tkb_pkg::out_item_t
//   cfg       in   APB psel/penable/pwrite     max_entries at byte 0
//
// An insert passes the accept state, then the insert state, in which every
// cell compares with the candidate and the chain shifts as the result
// loads the output register. A read gives max(1, fill) results, one per
// cycle through the entry select unless the output stalls. One request
// is in work at a time; the item register takes a new one once the
// previous one's last result is in the output register. A stalled output
// holds the chain. Reset clears the fill, resets the limit, no sweep.
// ----------------------------------------------------------------------------
module top_k_best_keeper #(
	parameter int CAPACITY = tkb_pkg::CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tkb_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tkb_pkg::out_item_t   out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import tkb_pkg::*;

	localparam int DEPTH = (CAPACITY < TABLE_MAX) ? CAPACITY : TABLE_MAX;
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INS  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;

	logic [1:0]        state_q;
	in_item_t          item_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  max_q;
	logic              out_vld_q;
	out_item_t         out_q;

	logic [CNT_W-1:0]  lim;
	logic [DEPTH-1:0]  occ;
	logic              out_free;
	logic              go;
	ins_status_t       status;
	logic signed [FIT_W-1:0] fit_arr [DEPTH];
	logic [TAG_W-1:0]        tag_arr [DEPTH];
	logic [CNT_W:0]    cnt_inc;
	logic [CNT_W-1:0]  cnt_new;
	logic              rd_empty;
	logic              rd_last;
	logic              res_fire;
	out_item_t         res;
	logic              cfg_wr;

	// Saturate the limit to one .. table depth
	always_comb begin
		if (max_q == '0) begin
			lim = CNT_W'(1);
		end else if (max_q > DEPTH_C) begin
			lim = DEPTH_C;
		end else begin
			lim = max_q;
		end
	end

	// Occupied ranks are the first cnt_q cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_occ
		assign occ[i] = cnt_q > CNT_W'(i);
	end

	assign out_free = !out_vld_q || out_ready;
	assign go       = (state_q == ST_INS) && out_free;

	tkb_chain #(
		.DEPTH(DEPTH)
	) u_chain (
		.clk     (clk),
		.occ     (occ),
		.cand_fit(item_q.new_fitness),
		.cand_tag(item_q.new_tag),
		.lim     (lim),
		.go      (go),
		.status  (status),
		.fit_arr (fit_arr),
		.tag_arr (tag_arr)
	);

	// Fill after an insert, trimmed to the limit
	assign cnt_inc = {1'b0, cnt_q} + (CNT_W + 1)'(status.kept);
	assign cnt_new = (cnt_inc > {1'b0, lim}) ? lim : cnt_inc[CNT_W-1:0];

	assign rd_empty = (cnt_q == '0);
	assign rd_last  = rd_empty || ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

	// Build the next result transaction
	always_comb begin
		res      = '0;
		res_fire = 1'b0;
		unique case (state_q)
			ST_INS: begin
				res_fire          = out_free;
				res.entry_fitness = item_q.new_fitness;
				res.entry_tag     = item_q.new_tag;
				res.entry_valid   = status.kept;
				res.was_kept      = status.kept;
				res.entry_rank    = status.kept ? status.pos[RANK_W-1:0] : '0;
				res.filled_count  = cnt_new;
				res.run_end       = 1'b1;
			end
			ST_RD: begin
				res_fire     = out_free;
				res.filled_count = cnt_q;
				res.run_end  = rd_last;
				if (!rd_empty) begin
					res.entry_valid   = 1'b1;
					res.entry_rank    = RANK_W'(idx_q);
					res.entry_fitness = fit_arr[idx_q];
					res.entry_tag     = tag_arr[idx_q];
				end
			end
			default: begin
				res_fire = 1'b0;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_ENTRIES);

	// Advance the request sequencer, fill count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			max_q     <= MAX_ENTRIES_RST;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				max_q <= pwdata[CNT_W-1:0];
			end
			if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (res_fire) begin
				out_vld_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= (in_data.req_type == REQ_READ) ? ST_RD : ST_INS;
					end
				end
				ST_INS: begin
					if (out_free) begin
						cnt_q   <= cnt_new;
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					if (out_free) begin
						if (rd_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted request and the result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (res_fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// Register readback
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_ENTRIES) begin
			prdata[CNT_W-1:0] = max_q;
		end
	end
	assign pready = 1'b1;

endmodule

/* rtl/tkb_checker.sv */
// ----------------------------------------------------------------------------
// tkb_checker: port-level checks of the top-k best keeper
// Watches the transaction ports over time and reports violations.
// ----------------------------------------------------------------------------
module tkb_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               out_valid,
	input  logic               out_ready,
	input  tkb_pkg::out_item_t out_data
);
	import tkb_pkg::*;

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request accepted while busy");

	// A kept candidate is reported as a valid entry
	a_kept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.was_kept |-> out_data.entry_valid)
		else $error("kept candidate without valid entry");

	// A reported entry ranks inside the fill, and the fill stays within the table maximum
	a_rank_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.entry_valid |->
			({1'b0, out_data.entry_rank} < out_data.filled_count) &&
			(out_data.filled_count <= CNT_W'(TABLE_MAX)))
		else $error("entry rank outside the fill");

	// A result without an entry always ends its request
	a_invalid_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.entry_valid |-> out_data.run_end)
		else $error("invalid entry not at run end");

endmodule

bind top_k_best_keeper tkb_checker u_tkb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
